[rtl/isb_pkg.sv]
// Shared constants, payload structs and cell control types for the indexed sequence buffer.
package isb_pkg;

	localparam int CAPACITY    = 64;
	localparam int VALUE_WIDTH = 32;
	localparam int OP_W        = 3;
	localparam int POS_W       = 7;
	localparam int DATA_W      = 32;
	localparam int CNT_W       = $clog2(CAPACITY + 1);
	localparam int GROUP       = 8;
	localparam int GROUPS      = (CAPACITY + GROUP - 1) / GROUP;
	localparam int XW          = (VALUE_WIDTH > DATA_W) ? VALUE_WIDTH : DATA_W;

	typedef enum logic [OP_W-1:0] {
		OP_READ      = 3'd0,
		OP_WRITE     = 3'd1,
		OP_APPEND    = 3'd2,
		OP_POP_BACK  = 3'd3,
		OP_INSERT    = 3'd4,
		OP_ERASE     = 3'd5,
		OP_ERASE_RUN = 3'd6,
		OP_CLEAR     = 3'd7
	} op_t;

	typedef logic [VALUE_WIDTH-1:0] value_t;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [POS_W-1:0]  position;
		logic [DATA_W-1:0] data_value;
		logic [POS_W-1:0]  run_length;
	} req_t;

	typedef struct packed {
		logic [DATA_W-1:0] read_value;
		logic [DATA_W-1:0] front_value;
		logic [DATA_W-1:0] back_value;
		logic [POS_W-1:0]  length;
		logic              is_empty;
		logic              error;
	} rsp_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_WRITE,
		CELL_INSERT,
		CELL_DOWN
	} cell_cmd_t;

	typedef struct packed {
		cell_cmd_t cmd;
		value_t    wdata;
	} cell_ctl_t;

	function automatic value_t to_value(logic [DATA_W-1:0] d);
		logic [XW-1:0] t;
		t = XW'(d);
		return t[VALUE_WIDTH-1:0];
	endfunction

	function automatic logic [DATA_W-1:0] to_field(value_t v);
		logic [XW-1:0] t;
		t = XW'(v);
		return t[DATA_W-1:0];
	endfunction

endpackage

[rtl/isb_cell.sv]
// One storage cell of the sequence chain, loading from itself, its neighbors or the write bus.
module isb_cell (
	input  logic               clk,
	input  isb_pkg::cell_ctl_t ctl,
	input  logic               hit,
	input  logic               above,
	input  isb_pkg::value_t    prev_val,
	input  isb_pkg::value_t    next_val,
	output isb_pkg::value_t    val
);
	import isb_pkg::*;

	value_t val_q;

	always_ff @(posedge clk) begin
		case (ctl.cmd)
			CELL_WRITE: begin
				if (hit) begin
					val_q <= ctl.wdata;
				end
			end
			CELL_INSERT: begin
				if (hit) begin
					val_q <= ctl.wdata;
				end else if (above) begin
					val_q <= prev_val;
				end
			end
			CELL_DOWN: begin
				if (hit || above) begin
					val_q <= next_val;
				end
			end
			default: begin
			end
		endcase
	end

	assign val = val_q;

endmodule

[rtl/indexed_sequence_buffer.sv]
// Top level of the indexed sequence buffer: control sequencer, cell chain and result gather.
// A request passes through S_EXEC, then S_SHIFT for each further step of an erase run, then S_GATH
// and S_DONE; its result is registered from S_DONE once no earlier result waits on rsp_stall.
// req_stall stays high until then, so a new request is not taken before the previous one is through.
// An erase run moves the chain one element per cycle; the read and back selects use a two-level
// registered OR tree over the cells. Reset clears the length and all control state at once.
module indexed_sequence_buffer (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  isb_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output isb_pkg::rsp_t rsp
);
	import isb_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_SHIFT,
		S_GATH,
		S_DONE
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  count_q;
	cell_cmd_t         cmd_q;
	logic [CNT_W-1:0]  at_q;
	value_t            wdata_q;
	logic [POS_W-1:0]  rem_q;
	logic              err_q;
	logic              rd_en_q;
	logic [CNT_W-1:0]  rd_pos_q;
	logic              rsp_valid_q;
	rsp_t              rsp_q;

	logic              accept;
	logic              dec_err;
	cell_cmd_t         dec_cmd;
	logic [CNT_W-1:0]  dec_at;
	logic [CNT_W-1:0]  dec_count;
	logic [POS_W-1:0]  dec_rem;
	logic              dec_rd;
	logic [CNT_W-1:0]  pos_c;
	logic [CNT_W-1:0]  run_c;
	logic [CNT_W:0]    span_end;
	logic              full;
	logic              rsp_free;

	cell_ctl_t         ctl;
	value_t            cell_val [CAPACITY];
	value_t            prev_val [CAPACITY];
	value_t            next_val [CAPACITY];
	value_t            rd_tap   [CAPACITY];
	value_t            bk_tap   [CAPACITY];
	value_t            rd_part_d  [GROUPS];
	value_t            bk_part_d  [GROUPS];
	value_t            rd_part_s1 [GROUPS];
	value_t            bk_part_s1 [GROUPS];
	value_t            rd_sum;
	value_t            bk_sum;
	logic [CNT_W-1:0]  back_idx;

	assign req_stall = (state_q != S_IDLE);
	assign accept    = req_valid && !req_stall;
	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	assign pos_c     = CNT_W'(req.position);
	assign run_c     = CNT_W'(req.run_length);
	assign span_end  = (CNT_W+1)'(req.position) + (CNT_W+1)'(req.run_length);
	assign full      = (count_q == CNT_W'(CAPACITY));

	always_comb begin
		dec_err   = 1'b0;
		dec_cmd   = CELL_HOLD;
		dec_at    = pos_c;
		dec_count = count_q;
		dec_rem   = '0;
		dec_rd    = 1'b0;
		case (op_t'(req.op))
			OP_READ: begin
				dec_err = !(pos_c < count_q);
				dec_rd  = !dec_err;
			end
			OP_WRITE: begin
				dec_err = !(pos_c < count_q);
				dec_cmd = CELL_WRITE;
			end
			OP_APPEND: begin
				dec_err   = full;
				dec_cmd   = CELL_WRITE;
				dec_at    = count_q;
				dec_count = count_q + 1'b1;
			end
			OP_POP_BACK: begin
				dec_err   = (count_q == '0);
				dec_count = count_q - 1'b1;
			end
			OP_INSERT: begin
				dec_err   = (pos_c > count_q) || full;
				dec_cmd   = CELL_INSERT;
				dec_count = count_q + 1'b1;
			end
			OP_ERASE: begin
				dec_err   = !(pos_c < count_q);
				dec_cmd   = CELL_DOWN;
				dec_count = count_q - 1'b1;
			end
			OP_ERASE_RUN: begin
				dec_err   = (span_end > (CNT_W+1)'(count_q));
				dec_cmd   = (req.run_length == '0) ? CELL_HOLD : CELL_DOWN;
				dec_rem   = req.run_length - 1'b1;
				dec_count = count_q - run_c;
			end
			OP_CLEAR: begin
				dec_count = '0;
			end
			default: begin
			end
		endcase
		if (dec_err) begin
			dec_cmd   = CELL_HOLD;
			dec_count = count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			cmd_q       <= CELL_HOLD;
			at_q        <= '0;
			wdata_q     <= '0;
			rem_q       <= '0;
			err_q       <= 1'b0;
			rd_en_q     <= 1'b0;
			rd_pos_q    <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			if (rsp_valid_q && !rsp_stall && state_q != S_DONE) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						cmd_q    <= dec_cmd;
						at_q     <= dec_at;
						wdata_q  <= to_value(req.data_value);
						rem_q    <= dec_rem;
						err_q    <= dec_err;
						rd_en_q  <= dec_rd;
						rd_pos_q <= pos_c;
						count_q  <= dec_count;
						state_q  <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (cmd_q == CELL_DOWN && rem_q != '0) begin
						state_q <= S_SHIFT;
					end else begin
						state_q <= S_GATH;
					end
				end
				S_SHIFT: begin
					rem_q <= rem_q - 1'b1;
					if (rem_q == POS_W'(1)) begin
						state_q <= S_GATH;
					end
				end
				S_GATH: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (rsp_free) begin
						rsp_q.read_value  <= to_field(rd_sum);
						rsp_q.front_value <= (count_q != '0) ? to_field(cell_val[0]) : '0;
						rsp_q.back_value  <= to_field(bk_sum);
						rsp_q.length      <= POS_W'(count_q);
						rsp_q.is_empty    <= (count_q == '0);
						rsp_q.error       <= err_q;
						rsp_valid_q       <= 1'b1;
						state_q           <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		ctl.wdata = wdata_q;
		case (state_q)
			S_EXEC:  ctl.cmd = cmd_q;
			S_SHIFT: ctl.cmd = CELL_DOWN;
			default: ctl.cmd = CELL_HOLD;
		endcase
	end

	assign back_idx = count_q - 1'b1;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		if (i == 0) begin : g_first
			assign prev_val[i] = '0;
		end else begin : g_mid
			assign prev_val[i] = cell_val[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign next_val[i] = '0;
		end else begin : g_inner
			assign next_val[i] = cell_val[i+1];
		end

		isb_cell u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.hit      (at_q == CNT_W'(i)),
			.above    (at_q < CNT_W'(i)),
			.prev_val (prev_val[i]),
			.next_val (next_val[i]),
			.val      (cell_val[i])
		);

		assign rd_tap[i] = (rd_en_q && rd_pos_q == CNT_W'(i)) ? cell_val[i] : '0;
		assign bk_tap[i] = (count_q != '0 && back_idx == CNT_W'(i)) ? cell_val[i] : '0;
	end

	always_comb begin
		for (int g = 0; g < GROUPS; g++) begin
			rd_part_d[g] = '0;
			bk_part_d[g] = '0;
			for (int k = 0; k < GROUP; k++) begin
				if (g * GROUP + k < CAPACITY) begin
					rd_part_d[g] = rd_part_d[g] | rd_tap[g*GROUP+k];
					bk_part_d[g] = bk_part_d[g] | bk_tap[g*GROUP+k];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_GATH) begin
			for (int g = 0; g < GROUPS; g++) begin
				rd_part_s1[g] <= rd_part_d[g];
				bk_part_s1[g] <= bk_part_d[g];
			end
		end
	end

	always_comb begin
		rd_sum = '0;
		bk_sum = '0;
		for (int g = 0; g < GROUPS; g++) begin
			rd_sum = rd_sum | rd_part_s1[g];
			bk_sum = bk_sum | bk_part_s1[g];
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("element count exceeds capacity");

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == S_EXEC)
		else $error("accepted request did not start execution");

	a_shift_rem: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SHIFT |-> rem_q != '0)
		else $error("shift state entered with no steps left");

	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q) == S_DONE)
		else $error("response raised outside the done state");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> rsp_q.is_empty == (rsp_q.length == '0))
		else $error("empty flag disagrees with length");

endmodule

[test/tb_indexed_sequence_buffer.sv]
// Self-checking testbench for the indexed sequence buffer: queued requests, a shadow model and a result checker.
module tb_indexed_sequence_buffer;
	import isb_pkg::*;

	localparam int LIMIT     = 1000000;
	localparam int N_RANDOM  = 1750;
	localparam int DRAIN     = 140;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	req_t pending_reqs[$];
	rsp_t expected_rsps[$];
	value_t model_cells[CAPACITY];
	int model_len = 0;
	int gen_len = 0;
	int mismatches = 0;
	int rsp_seen = 0;
	int cycle_count = 0;
	logic req_fire = 1'b0;
	int burst_left = 0;
	int gap_left = 0;
	int stall_mode = 0;
	int stall_mode_left = 0;
	int hold_left = 0;
	logic [1:0] stall_tick = '0;

	indexed_sequence_buffer u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	function automatic rsp_t apply_request(req_t r);
		rsp_t o;
		value_t v;
		int p;
		int n;
		int k;
		bit bad;
		o = '0;
		bad = 1'b0;
		p = r.position;
		n = r.run_length;
		v = r.data_value;
		case (r.op)
			OP_READ: begin
				if (p < model_len) o.read_value = model_cells[p];
				else bad = 1'b1;
			end
			OP_WRITE: begin
				if (p < model_len) model_cells[p] = v;
				else bad = 1'b1;
			end
			OP_APPEND: begin
				if (model_len < CAPACITY) begin
					model_cells[model_len] = v;
					model_len++;
				end else bad = 1'b1;
			end
			OP_POP_BACK: begin
				if (model_len > 0) model_len--;
				else bad = 1'b1;
			end
			OP_INSERT: begin
				if (p <= model_len && model_len < CAPACITY) begin
					for (k = model_len; k > p; k--) model_cells[k] = model_cells[k-1];
					model_cells[p] = v;
					model_len++;
				end else bad = 1'b1;
			end
			OP_ERASE: begin
				if (p < model_len) begin
					for (k = p; k + 1 < model_len; k++) model_cells[k] = model_cells[k+1];
					model_len--;
				end else bad = 1'b1;
			end
			OP_ERASE_RUN: begin
				if (p + n <= model_len) begin
					for (k = p; k + n < model_len; k++) model_cells[k] = model_cells[k+n];
					model_len -= n;
				end else bad = 1'b1;
			end
			default: begin
				model_len = 0;
			end
		endcase
		o.front_value = (model_len != 0) ? model_cells[0] : '0;
		o.back_value  = (model_len != 0) ? model_cells[model_len-1] : '0;
		o.length      = model_len[POS_W-1:0];
		o.is_empty    = (model_len == 0);
		o.error       = bad;
		return o;
	endfunction

	task automatic queue_item(op_t op, int pos, logic [DATA_W-1:0] d, int run);
		req_t r;
		r.op         = op;
		r.position   = pos[POS_W-1:0];
		r.data_value = d;
		r.run_length = run[POS_W-1:0];
		pending_reqs = {pending_reqs, r};
		case (op)
			OP_APPEND:    if (gen_len < CAPACITY) gen_len++;
			OP_POP_BACK:  if (gen_len > 0) gen_len--;
			OP_INSERT:    if (pos <= gen_len && gen_len < CAPACITY) gen_len++;
			OP_ERASE:     if (pos < gen_len) gen_len--;
			OP_ERASE_RUN: if (pos + run <= gen_len) gen_len -= run;
			OP_CLEAR:     gen_len = 0;
			default: ;
		endcase
	endtask

	task automatic fill_directed();
		queue_item(OP_READ, 0, 32'h0, 0);
		queue_item(OP_POP_BACK, 0, 32'h0, 0);
		queue_item(OP_ERASE, 0, 32'h0, 0);
		queue_item(OP_ERASE_RUN, 0, 32'h0, 0);
		queue_item(OP_INSERT, 1, 32'h1111_1111, 0);
		queue_item(OP_INSERT, 0, 32'hFFFF_FFFF, 0);
		queue_item(OP_APPEND, 0, 32'h0000_0000, 0);
		queue_item(OP_INSERT, 0, 32'hA5A5_A5A5, 0);
		queue_item(OP_INSERT, 3, 32'h5A5A_5A5A, 0);
		queue_item(OP_INSERT, 5, 32'h2222_2222, 0);
		queue_item(OP_WRITE, 1, 32'h1234_5678, 0);
		queue_item(OP_WRITE, 4, 32'h3333_3333, 0);
		queue_item(OP_READ, 3, 32'h0, 0);
		queue_item(OP_READ, 0, 32'h0, 0);
		queue_item(OP_READ, 127, 32'hFFFF_FFFF, 127);
		queue_item(OP_ERASE_RUN, 1, 32'h0, 2);
		queue_item(OP_ERASE_RUN, 2, 32'h0, 0);
		queue_item(OP_ERASE_RUN, 1, 32'h0, 2);
		queue_item(OP_ERASE, 0, 32'h0, 0);
		queue_item(OP_ERASE_RUN, 0, 32'h0, 127);
		queue_item(OP_CLEAR, 0, 32'h0, 0);
		queue_item(OP_CLEAR, 64, 32'hFFFF_FFFF, 64);
		queue_item(OP_APPEND, 0, 32'h0000_0001, 0);
		queue_item(OP_POP_BACK, 0, 32'h0, 0);
		queue_item(OP_POP_BACK, 0, 32'h0, 0);
	endtask

	task automatic fill_random(int total);
		int mode;
		int left;
		int sel;
		int p;
		int n;
		op_t op;
		logic [DATA_W-1:0] d;
		mode = 0;
		left = 0;
		for (int i = 0; i < total; i++) begin
			if (left == 0) begin
				sel = $urandom_range(0, 99);
				mode = (sel < 30) ? 0 : (sel < 55) ? 1 : (sel < 90) ? 2 : 3;
				left = $urandom_range(16, 64);
			end
			left--;
			sel = $urandom_range(0, 15);
			d = (sel == 0) ? '0 : (sel == 1) ? '1 : DATA_W'($urandom);
			if ($urandom_range(0, 9) == 0) p = $urandom_range(0, 127);
			else p = (gen_len > 0) ? $urandom_range(0, gen_len - 1) : 0;
			n = 0;
			sel = $urandom_range(0, 99);
			case (mode)
				0: begin
					op = (sel < 45) ? OP_APPEND : (sel < 80) ? OP_INSERT :
						(sel < 90) ? OP_READ : (sel < 99) ? OP_WRITE : OP_CLEAR;
				end
				1: begin
					op = (sel < 30) ? OP_POP_BACK : (sel < 55) ? OP_ERASE :
						(sel < 75) ? OP_ERASE_RUN : (sel < 90) ? OP_READ : OP_APPEND;
				end
				2: begin
					op = (sel < 25) ? OP_READ : (sel < 50) ? OP_WRITE :
						(sel < 65) ? OP_INSERT : (sel < 80) ? OP_ERASE :
						(sel < 90) ? OP_APPEND : (sel < 95) ? OP_POP_BACK :
						(sel < 99) ? OP_ERASE_RUN : OP_CLEAR;
				end
				default: begin
					op = op_t'($urandom_range(0, 7));
					if (op == OP_CLEAR && $urandom_range(0, 3) != 0) op = OP_READ;
					p = $urandom_range(0, 127);
					n = $urandom_range(0, 127);
				end
			endcase
			if (mode != 3) begin
				if (op == OP_INSERT && p < 128 && $urandom_range(0, 9) != 0) begin
					sel = $urandom_range(0, 5);
					p = (sel == 0) ? 0 : (sel == 1) ? gen_len : $urandom_range(0, gen_len);
				end
				if (op == OP_ERASE_RUN) begin
					if ($urandom_range(0, 9) == 0) n = $urandom_range(0, 127);
					else if (p <= gen_len) n = $urandom_range(0, (gen_len - p > 8) ? 8 : gen_len - p);
				end
			end
			queue_item(op, p, d, n);
		end
	endtask

	task automatic report(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
		$display("mismatch at result %0d: %s got %h want %h", rsp_seen, what, got, want);
		mismatches++;
	endtask

	always @(negedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else if (!req_valid || req_fire) begin
			if (gap_left > 0) begin
				req_valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (pending_reqs.size() > 0) begin
				req <= pending_reqs.pop_front();
				req_valid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 40);
					gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else begin
			if (stall_mode_left == 0) begin
				stall_mode <= $urandom_range(0, 3);
				stall_mode_left <= $urandom_range(50, 300);
			end else begin
				stall_mode_left <= stall_mode_left - 1;
			end
			case (stall_mode)
				0: rsp_stall <= 1'b0;
				1: rsp_stall <= ($urandom_range(0, 2) == 0);
				2: rsp_stall <= (stall_tick == 2'd3);
				default: begin
					if (hold_left == 0) begin
						rsp_stall <= !rsp_stall;
						hold_left <= rsp_stall ? $urandom_range(1, 20) : $urandom_range(3, 16);
					end else begin
						hold_left <= hold_left - 1;
					end
				end
			endcase
			stall_tick <= stall_tick + 2'd1;
		end
	end

	always @(posedge clk) begin : monitor
		rsp_t want;
		if (!arst_n) begin
			req_fire <= 1'b0;
		end else begin
			req_fire <= req_valid && !req_stall;
			if (req_valid && !req_stall) expected_rsps = {expected_rsps, apply_request(req)};
			if (rsp_valid && !rsp_stall) begin
				if (expected_rsps.size() == 0) begin
					report("result with no transfer pending", rsp.read_value, '0);
				end else begin
					want = expected_rsps.pop_front();
					if (rsp.read_value !== want.read_value)
						report("read_value", rsp.read_value, want.read_value);
					if (rsp.front_value !== want.front_value)
						report("front_value", rsp.front_value, want.front_value);
					if (rsp.back_value !== want.back_value)
						report("back_value", rsp.back_value, want.back_value);
					if (rsp.length !== want.length)
						report("length", DATA_W'(rsp.length), DATA_W'(want.length));
					if (rsp.is_empty !== want.is_empty)
						report("is_empty", DATA_W'(rsp.is_empty), DATA_W'(want.is_empty));
					if (rsp.error !== want.error)
						report("error", DATA_W'(rsp.error), DATA_W'(want.error));
				end
				rsp_seen++;
			end
		end
	end

	initial begin
		fill_directed();
		fill_random(N_RANDOM);
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		while ((pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
			&& cycle_count < LIMIT)
			@(negedge clk);
		if (cycle_count >= LIMIT) begin
			$display("tb_indexed_sequence_buffer: errors");
		end else begin
			repeat (DRAIN) @(negedge clk);
			if (expected_rsps.size() != 0)
				report("results never arrived", '0, DATA_W'(expected_rsps.size()));
			if (mismatches == 0)
				$display("tb_indexed_sequence_buffer: clean");
			else
				$display("tb_indexed_sequence_buffer: errors");
		end
		$finish;
	end

endmodule

[files.f]
rtl/isb_pkg.sv
rtl/isb_cell.sv
rtl/indexed_sequence_buffer.sv
test/tb_indexed_sequence_buffer.sv
